[hw/rtl/tts_pkg.sv]
// ----------------------------------------------------------------------------
// Taylor trig and hyperbolic unit package
// Shared widths, request and status codes, payload types and the reciprocal
// table used for the exact division of series terms by their degree.
// ----------------------------------------------------------------------------
package tts_pkg;

	localparam int TERMS      = 9;
	localparam int FRAC_BITS  = 24;
	localparam int IFRAC      = 32;
	localparam int ANG_W      = 28;
	localparam int VAL_W      = 32;
	localparam int XM_W       = ANG_W + IFRAC - FRAC_BITS;
	localparam int T_W        = 42;
	localparam int ACC_W      = 48;
	localparam int N_W        = 45;
	localparam int RCP_W      = 50;
	localparam int RCP_SH     = 50;
	localparam int STEPS      = 2 * TERMS;
	localparam int DEG_W      = 5;
	localparam int Q_W        = 32;
	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = Q_W / DIV_BITS;
	localparam int LATENCY    = 1 + 4 * STEPS + 2 + DIV_STAGES + 2;

	localparam logic [2:0] REQ_SIN  = 3'd0;
	localparam logic [2:0] REQ_COS  = 3'd1;
	localparam logic [2:0] REQ_TAN  = 3'd2;
	localparam logic [2:0] REQ_SINH = 3'd3;
	localparam logic [2:0] REQ_COSH = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [2:0]              req_type;
		logic signed [ANG_W-1:0] angle;
	} request_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [1:0]              status;
	} result_t;

	typedef struct packed {
		logic                    valid;
		logic [2:0]              req_type;
		logic                    xneg;
		logic [XM_W-1:0]         xm;
		logic [T_W-1:0]          t;
		logic signed [ACC_W-1:0] acc_odd;
		logic signed [ACC_W-1:0] acc_even;
	} ser_t;

	typedef struct packed {
		logic                    valid;
		logic [2:0]              req_type;
		logic signed [VAL_W-1:0] odd_v;
		logic                    odd_sat;
		logic signed [VAL_W-1:0] even_v;
		logic                    even_sat;
	} fin_t;

	// Sine, cosine and tangent use alternating signs.
	function automatic logic alt_of(input logic [2:0] rt);
		return rt inside {REQ_SIN, REQ_COS, REQ_TAN};
	endfunction

	// Ceiling of 2^50 / d for the degrees that occur in the series.
	function automatic logic [RCP_W-1:0] recip(input logic [DEG_W-1:0] d);
		logic [RCP_W-1:0] m;
		case (d)
			5'd2:    m = 50'd562949953421312;
			5'd3:    m = 50'd375299968947542;
			5'd4:    m = 50'd281474976710656;
			5'd5:    m = 50'd225179981368525;
			5'd6:    m = 50'd187649984473771;
			5'd7:    m = 50'd160842843834661;
			5'd8:    m = 50'd140737488355328;
			5'd9:    m = 50'd125099989649181;
			5'd10:   m = 50'd112589990684263;
			5'd11:   m = 50'd102354536985694;
			5'd12:   m = 50'd93824992236886;
			5'd13:   m = 50'd86607685141741;
			5'd14:   m = 50'd80421421917331;
			5'd15:   m = 50'd75059993789509;
			5'd16:   m = 50'd70368744177664;
			5'd17:   m = 50'd66229406284861;
			5'd18:   m = 50'd62549994824591;
			5'd19:   m = 50'd59257889833823;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

[hw/rtl/tts_term_step.sv]
// ----------------------------------------------------------------------------
// Series term step
// Four register stages that add the incoming term to its sum and raise the
// term by one degree: multiply by the angle with rounding, then divide by the
// degree through a reciprocal product.
// ----------------------------------------------------------------------------
module tts_term_step (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tts_pkg::DEG_W-1:0]   d,
	input  tts_pkg::ser_t               in_s,
	output tts_pkg::ser_t               out_s
);
	import tts_pkg::*;

	localparam int H_L  = T_W / 2;
	localparam int H_H  = T_W - H_L;
	localparam int PH_W = H_H + XM_W;
	localparam int PR_W = T_W + XM_W;
	localparam int NL_W = 23;
	localparam int ML_W = 25;
	localparam int PP_W = 48;
	localparam int SM_W = 96;

	ser_t                    a_s1, b_s2, c_s3, d_s4;
	logic [PH_W-1:0]         ph_s1, pl_s1;
	logic [N_W-1:0]          n_s2;
	logic [PP_W-1:0]         pp_ll_s3, pp_lh_s3, pp_hl_s3, pp_hh_s3;

	logic [DEG_W-1:0]        deg;
	logic                    tneg;
	logic [ACC_W-1:0]        text, tterm;
	logic [PR_W-1:0]         prod;
	logic [RCP_W-1:0]        m;
	logic [SM_W-1:0]         qsum;
	ser_t                    a_nxt, d_nxt;

	assign deg   = d - DEG_W'(1);
	assign tneg  = (deg[0] & in_s.xneg) ^ (alt_of(in_s.req_type) & deg[1]);
	assign text  = ACC_W'(in_s.t);
	assign tterm = tneg ? (~text + ACC_W'(1)) : text;

	assign prod = {ph_s1, {H_L{1'b0}}} + PR_W'(pl_s1) + (PR_W'(1) << (IFRAC - 1));
	assign m    = recip(d);
	assign qsum = (SM_W'(pp_hh_s3) << (NL_W + ML_W)) + (SM_W'(pp_lh_s3) << ML_W)
		+ (SM_W'(pp_hl_s3) << NL_W) + SM_W'(pp_ll_s3);

	always_comb begin
		a_nxt = in_s;
		if (deg[0]) begin
			a_nxt.acc_odd = in_s.acc_odd + $signed(tterm);
		end else begin
			a_nxt.acc_even = in_s.acc_even + $signed(tterm);
		end
		d_nxt   = c_s3;
		d_nxt.t = qsum[RCP_SH+T_W-1:RCP_SH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_s1 <= '0;
			b_s2 <= '0;
			c_s3 <= '0;
			d_s4 <= '0;
		end else begin
			a_s1 <= a_nxt;
			b_s2 <= a_s1;
			c_s3 <= b_s2;
			d_s4 <= d_nxt;
		end
	end

	always_ff @(posedge clk) begin
		ph_s1    <= PH_W'(in_s.t[T_W-1:H_L]) * PH_W'(in_s.xm);
		pl_s1    <= PH_W'(in_s.t[H_L-1:0]) * PH_W'(in_s.xm);
		n_s2     <= prod[IFRAC+N_W-1:IFRAC] + N_W'(d >> 1);
		pp_ll_s3 <= PP_W'(n_s2[NL_W-1:0]) * PP_W'(m[ML_W-1:0]);
		pp_lh_s3 <= PP_W'(n_s2[NL_W-1:0]) * PP_W'(m[RCP_W-1:ML_W]);
		pp_hl_s3 <= PP_W'(n_s2[N_W-1:NL_W]) * PP_W'(m[ML_W-1:0]);
		pp_hh_s3 <= PP_W'(n_s2[N_W-1:NL_W]) * PP_W'(m[RCP_W-1:ML_W]);
	end

	assign out_s = d_s4;

endmodule

[hw/rtl/tts_finish.sv]
// ----------------------------------------------------------------------------
// Series finish
// Adds the last odd term and rounds both sums to the output format with
// saturation.
// ----------------------------------------------------------------------------
module tts_finish (
	input  logic           clk,
	input  logic           arst_n,
	input  tts_pkg::ser_t  in_s,
	output tts_pkg::fin_t  out_s
);
	import tts_pkg::*;

	localparam int  SH       = IFRAC - FRAC_BITS;
	localparam logic LAST_ALT = ((2 * TERMS + 1) % 4) == 3;

	logic                    v_s1;
	logic [2:0]              rt_s1;
	logic signed [ACC_W-1:0] odd_s1, even_s1;
	fin_t                    f_s2;

	logic                    tneg;
	logic [ACC_W-1:0]        text, tterm;
	logic [VAL_W:0]          odd_r, even_r;

	function automatic logic [VAL_W:0] to_out(input logic signed [ACC_W-1:0] r);
		logic             neg;
		logic [ACC_W-1:0] u;
		logic [ACC_W-1:0] rnd;
		logic             sat;
		logic [VAL_W-1:0] v;
		neg = r[ACC_W-1];
		u   = neg ? (~r + ACC_W'(1)) : r;
		rnd = (u + (ACC_W'(1) << (SH - 1))) >> SH;
		sat = 1'b0;
		if (!neg && (rnd[ACC_W-1:VAL_W-1] != '0)) begin
			sat = 1'b1;
			v   = VAL_MAX;
		end else if (neg && ((rnd[ACC_W-1:VAL_W] != '0) ||
				(rnd[VAL_W-1] && (rnd[VAL_W-2:0] != '0)))) begin
			sat = 1'b1;
			v   = VAL_MIN;
		end else begin
			v = neg ? (~rnd[VAL_W-1:0] + VAL_W'(1)) : rnd[VAL_W-1:0];
		end
		return {sat, v};
	endfunction

	assign tneg   = in_s.xneg ^ (alt_of(in_s.req_type) & LAST_ALT);
	assign text   = ACC_W'(in_s.t);
	assign tterm  = tneg ? (~text + ACC_W'(1)) : text;
	assign odd_r  = to_out(odd_s1);
	assign even_r = to_out(even_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			f_s2 <= '0;
		end else begin
			v_s1          <= in_s.valid;
			f_s2.valid    <= v_s1;
			f_s2.req_type <= rt_s1;
			f_s2.odd_v    <= odd_r[VAL_W-1:0];
			f_s2.odd_sat  <= odd_r[VAL_W];
			f_s2.even_v   <= even_r[VAL_W-1:0];
			f_s2.even_sat <= even_r[VAL_W];
		end
	end

	always_ff @(posedge clk) begin
		rt_s1   <= in_s.req_type;
		odd_s1  <= in_s.acc_odd + $signed(tterm);
		even_s1 <= in_s.acc_even;
	end

	assign out_s = f_s2;

endmodule

[hw/rtl/tts_tan_div.sv]
// ----------------------------------------------------------------------------
// Tangent divider and result select
// Forms sine over cosine with a pipelined restoring divider, two quotient
// bits per stage, and selects the final value and status for every request.
// ----------------------------------------------------------------------------
module tts_tan_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tts_pkg::fin_t     in_s,
	output logic              done,
	output tts_pkg::result_t  result
);
	import tts_pkg::*;

	localparam int NN_W = VAL_W + FRAC_BITS;

	typedef struct packed {
		logic           valid;
		logic           is_tan;
		logic           divz;
		logic           sat_in;
		logic           ovf;
		logic           qneg;
		result_t        base;
		logic [Q_W-1:0] cm;
		logic [Q_W:0]   r;
		logic [Q_W-1:0] nlo;
		logic [Q_W-1:0] q;
	} div_t;

	div_t           stg_s [DIV_STAGES+1];
	logic           done_q;
	result_t        result_q;

	logic [Q_W-1:0] sm, cm;
	logic [NN_W-1:0] nn;
	result_t        base;
	div_t           pre;
	div_t           last;
	result_t        fin;

	function automatic div_t div_step(input div_t x);
		div_t         y;
		logic [Q_W:0] r2;
		int           i;
		y = x;
		for (i = 0; i < DIV_BITS; i++) begin
			r2    = {y.r[Q_W-1:0], y.nlo[Q_W-1]};
			y.nlo = {y.nlo[Q_W-2:0], 1'b0};
			if (r2 >= {1'b0, y.cm}) begin
				r2  = r2 - {1'b0, y.cm};
				y.q = {y.q[Q_W-2:0], 1'b1};
			end else begin
				y.q = {y.q[Q_W-2:0], 1'b0};
			end
			y.r = r2;
		end
		return y;
	endfunction

	assign sm = in_s.odd_v[VAL_W-1] ? (~in_s.odd_v + VAL_W'(1)) : in_s.odd_v;
	assign cm = in_s.even_v[VAL_W-1] ? (~in_s.even_v + VAL_W'(1)) : in_s.even_v;
	assign nn = {sm, {FRAC_BITS{1'b0}}} + NN_W'(cm >> 1);

	always_comb begin
		case (in_s.req_type)
			REQ_SIN, REQ_SINH: begin
				base.value  = in_s.odd_v;
				base.status = in_s.odd_sat ? ST_SAT : ST_OK;
			end
			REQ_COS, REQ_COSH: begin
				base.value  = in_s.even_v;
				base.status = in_s.even_sat ? ST_SAT : ST_OK;
			end
			default: begin
				base.value  = '0;
				base.status = ST_OK;
			end
		endcase
	end

	always_comb begin
		pre.valid  = in_s.valid;
		pre.is_tan = in_s.req_type == REQ_TAN;
		pre.divz   = in_s.even_v == '0;
		pre.sat_in = in_s.odd_sat | in_s.even_sat;
		pre.ovf    = Q_W'(nn[NN_W-1:Q_W]) >= cm;
		pre.qneg   = in_s.odd_v[VAL_W-1] ^ in_s.even_v[VAL_W-1];
		pre.base   = base;
		pre.cm     = cm;
		pre.r      = (Q_W + 1)'(nn[NN_W-1:Q_W]);
		pre.nlo    = nn[Q_W-1:0];
		pre.q      = '0;
	end

	assign last = stg_s[DIV_STAGES];

	always_comb begin
		fin = last.base;
		if (last.is_tan) begin
			if (last.divz) begin
				fin.value  = '0;
				fin.status = ST_DIVZ;
			end else begin
				fin.status = last.sat_in ? ST_SAT : ST_OK;
				if (!last.qneg && (last.ovf || last.q[Q_W-1])) begin
					fin.value  = VAL_MAX;
					fin.status = ST_SAT;
				end else if (last.qneg && (last.ovf ||
						(last.q[Q_W-1] && (last.q[Q_W-2:0] != '0)))) begin
					fin.value  = VAL_MIN;
					fin.status = ST_SAT;
				end else begin
					fin.value = last.qneg ? (~last.q + Q_W'(1)) : last.q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STAGES; k++) begin
				stg_s[k] <= '0;
			end
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			stg_s[0] <= pre;
			for (int k = 0; k < DIV_STAGES; k++) begin
				stg_s[k+1] <= div_step(stg_s[k]);
			end
			done_q   <= last.valid;
			result_q <= fin;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[hw/rtl/taylor_trig_hyperbolic_unit.sv]
// ----------------------------------------------------------------------------
// Taylor trig and hyperbolic unit
// Sine, cosine, tangent and hyperbolic sine and cosine of a Q4.24 angle from
// truncated Taylor series, with tangent formed by a pipelined divider.
// ----------------------------------------------------------------------------
//  Channel  | Signals                   | Handshake
//  ---------+---------------------------+-----------------------------------
//  request  | start, busy, request      | taken when start is high, busy low
//  result   | done, result              | done marks each result, no stall
//
// The unit takes one request every cycle; busy stays low.
// Each result passes through one input stage, four stages for each of the 18
// term steps, two rounding stages and the 16-stage divider with its entry and
// exit registers.
// Reset clears all valid bits; requests in flight are dropped.
// ----------------------------------------------------------------------------
module taylor_trig_hyperbolic_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tts_pkg::request_t request,
	output logic              done,
	output tts_pkg::result_t  result
);
	import tts_pkg::*;

	ser_t             front_s1;
	ser_t             chain [STEPS+1];
	fin_t             fin;

	logic [ANG_W-1:0] ang_u, mag;
	logic             xneg;

	assign busy  = 1'b0;
	assign ang_u = request.angle;
	assign xneg  = ang_u[ANG_W-1];
	assign mag   = xneg ? (~ang_u + ANG_W'(1)) : ang_u;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_s1 <= '0;
		end else begin
			front_s1.valid    <= start & ~busy;
			front_s1.req_type <= request.req_type;
			front_s1.xneg     <= xneg;
			front_s1.xm       <= {mag, {(IFRAC - FRAC_BITS){1'b0}}};
			front_s1.t        <= T_W'({mag, {(IFRAC - FRAC_BITS){1'b0}}});
			front_s1.acc_odd  <= '0;
			front_s1.acc_even <= ACC_W'(1) << IFRAC;
		end
	end

	assign chain[0] = front_s1;

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		tts_term_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (DEG_W'(g + 2)),
			.in_s   (chain[g]),
			.out_s  (chain[g+1])
		);
	end

	tts_finish u_finish (
		.clk    (clk),
		.arst_n (arst_n),
		.in_s   (chain[STEPS]),
		.out_s  (fin)
	);

	tts_tan_div u_tan_div (
		.clk    (clk),
		.arst_n (arst_n),
		.in_s   (fin),
		.done   (done),
		.result (result)
	);

endmodule

[hw/rtl/tts_checker.sv]
// ----------------------------------------------------------------------------
// Taylor trig and hyperbolic unit checker
// Port-level checks on request to result timing and result status coding.
// ----------------------------------------------------------------------------
module tts_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input tts_pkg::result_t  result
);
	import tts_pkg::*;

	a_req_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("A request did not produce a result on time.");

	a_result_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("A result appeared without a matching request.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ST_OK || result.status == ST_SAT ||
			result.status == ST_DIVZ))
		else $error("A result carried an undefined status.");

	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_DIVZ) |-> (result.value == '0))
		else $error("A zero-cosine tangent returned a nonzero value.");

endmodule

bind taylor_trig_hyperbolic_unit tts_checker u_tts_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Taylor trig and hyperbolic unit testbench
// Sends directed and random requests and predicts each result with an
// independent fixed-point series model. Every result is compared field by
// field, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import tts_pkg::*;

	localparam longint unsigned TERM_CAP = 64'd1 << 58;
	localparam longint          OUT_HI   = 64'sd2147483647;
	localparam longint          OUT_LO   = -64'sd2147483648;
	localparam int              CYCLE_CAP = 400000;

	class trig_predictor;
		result_t pending[$];
		int      errors;

		function new();
			errors = 0;
		endfunction

		function longint unsigned mul_round(longint unsigned a, longint unsigned b,
				output bit ovf);
			logic [127:0] p;
			p = {64'd0, a} * {64'd0, b} + 128'h8000_0000;
			p = p >> 32;
			ovf = p >= TERM_CAP;
			return p[63:0];
		endfunction

		function int sum_series(longint unsigned xm, bit xneg, bit odd, bit alt,
				output longint acc);
			longint unsigned t, p;
			longint unsigned d;
			bit base_neg, neg, ovf;
			longint s;
			t = odd ? xm : 64'd1 << 32;
			d = odd ? 1 : 0;
			base_neg = odd && xneg;
			s = base_neg ? -longint'(t) : longint'(t);
			acc = 0;
			for (int k = 1; k <= TERMS; k++) begin
				neg = base_neg != (alt && k[0]);
				for (int j = 0; j < 2; j++) begin
					d++;
					p = mul_round(t, xm, ovf);
					if (ovf)
						return neg ? -1 : 1;
					t = (p + d / 2) / d;
				end
				s += neg ? -longint'(t) : longint'(t);
			end
			acc = s;
			return 0;
		endfunction

		function longint round_out(longint r, inout bit sat);
			bit neg;
			longint unsigned u;
			neg = r < 0;
			u = neg ? -r : r;
			u = (u + (64'd1 << (IFRAC - FRAC_BITS - 1))) >> (IFRAC - FRAC_BITS);
			if (!neg && u > OUT_HI) begin
				sat = 1;
				return OUT_HI;
			end
			if (neg && u > 64'd2147483648) begin
				sat = 1;
				return OUT_LO;
			end
			return neg ? -longint'(u) : longint'(u);
		endfunction

		function longint eval_fn(longint unsigned xm, bit xneg, bit odd, bit alt,
				inout bit sat);
			longint acc;
			int o;
			o = sum_series(xm, xneg, odd, alt, acc);
			if (o != 0) begin
				sat = 1;
				return o > 0 ? OUT_HI : OUT_LO;
			end
			return round_out(acc, sat);
		endfunction

		function void note(request_t rq);
			longint ang, v, sv, cv;
			longint unsigned xm, sm, cm, q;
			bit xneg, sat, qneg;
			result_t r;
			ang = longint'(rq.angle);
			xneg = ang < 0;
			xm = (xneg ? -ang : ang) << (IFRAC - FRAC_BITS);
			v = 0;
			sat = 0;
			r.status = ST_OK;
			case (rq.req_type)
				REQ_SIN:  v = eval_fn(xm, xneg, 1, 1, sat);
				REQ_COS:  v = eval_fn(xm, xneg, 0, 1, sat);
				REQ_SINH: v = eval_fn(xm, xneg, 1, 0, sat);
				REQ_COSH: v = eval_fn(xm, xneg, 0, 0, sat);
				REQ_TAN: begin
					sv = eval_fn(xm, xneg, 1, 1, sat);
					cv = eval_fn(xm, xneg, 0, 1, sat);
					if (cv == 0) begin
						v = 0;
						sat = 0;
						r.status = ST_DIVZ;
					end else begin
						sm = sv < 0 ? -sv : sv;
						cm = cv < 0 ? -cv : cv;
						q = ((sm << FRAC_BITS) + cm / 2) / cm;
						qneg = (sv < 0) != (cv < 0);
						if (!qneg && q > OUT_HI) begin
							v = OUT_HI;
							sat = 1;
						end else if (qneg && q > 64'd2147483648) begin
							v = OUT_LO;
							sat = 1;
						end else begin
							v = qneg ? -longint'(q) : longint'(q);
						end
					end
				end
				default: v = 0;
			endcase
			if (sat)
				r.status = ST_SAT;
			r.value = v[31:0];
			pending.push_back(r);
		endfunction

		function void check(result_t got);
			result_t exp_r;
			if (pending.size() == 0) begin
				$error("result with no request outstanding: value %h status %0d",
					got.value, got.status);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.value !== exp_r.value) begin
				$error("value: expected %h, got %h", exp_r.value, got.value);
				errors++;
			end
			if (got.status !== exp_r.status) begin
				$error("status: expected %0d, got %0d", exp_r.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	request_t request;
	logic     done;
	result_t  result;

	trig_predictor model = new();
	int cycles = 0;
	int idle_pct = 0;

	taylor_trig_hyperbolic_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (arst_n && start === 1'b1 && busy === 1'b0)
			model.note(request);
		if (arst_n && done === 1'b1)
			model.check(result);
		if (cycles > CYCLE_CAP) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send(logic [2:0] rt, logic signed [ANG_W-1:0] ang);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request.req_type <= rt;
		request.angle <= ang;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (model.pending.size() != 0) @(posedge clk);
	endtask

	task automatic random_burst(int n);
		logic [2:0] rt;
		logic signed [ANG_W-1:0] ang;
		for (int i = 0; i < n; i++) begin
			rt = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			case ($urandom_range(3))
				0: ang = ANG_W'($urandom());
				1: ang = ANG_W'($signed($urandom_range(0, 2 * 32'd2097152))
					- 32'sd2097152);
				default: ang = ANG_W'($signed($urandom_range(0, 2 * 32'd67108864))
					- 32'sd67108864);
			endcase
			send(rt, ang);
		end
	endtask

	initial begin
		logic signed [ANG_W-1:0] corners[6];
		corners = '{28'sd0, 28'sd67108864, -28'sd67108864, 28'sh7FF_FFFF,
			28'sh800_0000, 28'sd1};
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corners[i])
			send(i % 2 ? REQ_COSH : REQ_SINH, corners[i]);
		for (int r = 0; r < 8; r++)
			send(3'(r), corners[r % 6]);
		for (int k = -2; k <= 2; k++) begin
			send(REQ_TAN, 28'sd26353590 + k);
			send(REQ_TAN, -28'sd26353590 + k);
		end
		send(REQ_TAN, 28'sd67108864);
		send(REQ_COS, -28'sd1);

		idle_pct = 10;
		random_burst(480);
		drain();
		idle_pct = 57;
		random_burst(480);
		idle_pct = 0;
		random_burst(470);
		drain();
		repeat (LATENCY + 20) @(posedge clk);

		if (model.pending.size() != 0) begin
			$error("%0d results never arrived", model.pending.size());
			model.errors++;
		end
		if (model.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

[taylor_trig_hyperbolic_unit.f]
hw/rtl/tts_pkg.sv
hw/rtl/tts_term_step.sv
hw/rtl/tts_finish.sv
hw/rtl/tts_tan_div.sv
hw/rtl/taylor_trig_hyperbolic_unit.sv
hw/rtl/tts_checker.sv
bench/tb.sv
